// ===== hdl/pprg_pkg.sv =====
// Package: shared widths, register indices, reset values and limits of the ray generator.
`default_nettype none
package pprg_pkg;

  // payload widths
  localparam int PIX_W  = 12;
  localparam int SUB_W  = 4;
  localparam int DIR_W  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indices
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_U       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_V       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_W       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DISTANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES       = 3'd7;

  // reset values: u = (1,0,0), v = (0,1,0), w = (0,0,1), d = 500.0, s = 1.0
  localparam logic [47:0] RST_BASIS_U       = 48'h0000_0000_4000;
  localparam logic [47:0] RST_BASIS_V       = 48'h0000_4000_0000;
  localparam logic [47:0] RST_BASIS_W       = 48'h4000_0000_0000;
  localparam logic [23:0] RST_VIEW_DISTANCE = 24'd128000;
  localparam logic [23:0] RST_PIXEL_SIZE    = 24'd65536;
  localparam logic [12:0] RST_IMAGE_SIDE    = 13'd512;
  localparam logic [4:0]  RST_SAMPLES       = 5'd1;

  // limits
  localparam int MAX_IMAGE_SIDE       = 4096;
  localparam int MAX_SAMPLES_PER_SIDE = 16;
  localparam int DIR_FRAC_BITS_DEF    = 14;

endpackage
`default_nettype wire

// ===== hdl/pprg_if.sv =====
// Interfaces: sample request channel and ray direction channel.
`default_nettype none
interface pprg_req_if;
  logic                       valid;
  logic                       ready;
  logic [pprg_pkg::PIX_W-1:0] pixel_row;
  logic [pprg_pkg::PIX_W-1:0] pixel_col;
  logic [pprg_pkg::SUB_W-1:0] sub_row;
  logic [pprg_pkg::SUB_W-1:0] sub_col;

  modport source (output valid, pixel_row, pixel_col, sub_row, sub_col, input ready);
  modport sink   (input valid, pixel_row, pixel_col, sub_row, sub_col, output ready);
endinterface

interface pprg_ray_if;
  logic                              valid;
  logic                              ready;
  logic signed [pprg_pkg::DIR_W-1:0] dir_x;
  logic signed [pprg_pkg::DIR_W-1:0] dir_y;
  logic signed [pprg_pkg::DIR_W-1:0] dir_z;
  logic                              zero_length;

  modport source (output valid, dir_x, dir_y, dir_z, zero_length, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, zero_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/pinhole_primary_ray_generator_unit.sv =====
// Pinhole camera primary ray generator: one unit direction per sample request.
// Takes one request per clock and returns one ray per clock while ray.ready is high.
// Its stages include a 32-stage square-root pipeline and a DIR_FRAC_BITS+1 stage
// divider. Each pipeline stage holds only when the one after it is full and held,
// so bubbles close up while a finished ray waits. Configuration is exact
// integer arithmetic up to the normalisation; write registers only while
// no request is in flight.
`default_nettype none
module pinhole_primary_ray_generator_unit #(
  parameter int DIR_FRAC_BITS = pprg_pkg::DIR_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wen,
  input  wire logic [pprg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pprg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  pprg_req_if.sink                                req,
  pprg_ray_if.source                              ray
);

  localparam int QW      = DIR_FRAC_BITS + 1;   // quotient bits
  localparam int RW      = 31 + DIR_FRAC_BITS;  // divider remainder width
  localparam int NRM_N   = 6;
  localparam int RT_N    = 32;
  localparam int ST_NRM0 = 6;
  localparam int ST_SQ   = ST_NRM0 + NRM_N;
  localparam int ST_SSUM = ST_SQ + 1;
  localparam int ST_RT0  = ST_SSUM + 1;
  localparam int ST_DIVP = ST_RT0 + RT_N;
  localparam int ST_DV0  = ST_DIVP + 1;
  localparam int ST_OUT  = ST_DV0 + QW;
  localparam int NS      = ST_OUT + 1;

  // configuration registers
  logic [47:0] basis_u, basis_v, basis_w;
  logic [23:0] view_distance, pixel_size;
  logic [12:0] image_width, image_height;
  logic [4:0]  samples_per_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_u          <= pprg_pkg::RST_BASIS_U;
      basis_v          <= pprg_pkg::RST_BASIS_V;
      basis_w          <= pprg_pkg::RST_BASIS_W;
      view_distance    <= pprg_pkg::RST_VIEW_DISTANCE;
      pixel_size       <= pprg_pkg::RST_PIXEL_SIZE;
      image_width      <= pprg_pkg::RST_IMAGE_SIDE;
      image_height     <= pprg_pkg::RST_IMAGE_SIDE;
      samples_per_side <= pprg_pkg::RST_SAMPLES;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pprg_pkg::REG_BASIS_U:       basis_u          <= cfg_wdata;
        pprg_pkg::REG_BASIS_V:       basis_v          <= cfg_wdata;
        pprg_pkg::REG_BASIS_W:       basis_w          <= cfg_wdata;
        pprg_pkg::REG_VIEW_DISTANCE: view_distance    <= cfg_wdata[23:0];
        pprg_pkg::REG_PIXEL_SIZE:    pixel_size       <= cfg_wdata[23:0];
        pprg_pkg::REG_IMAGE_WIDTH:   image_width      <= cfg_wdata[12:0];
        pprg_pkg::REG_IMAGE_HEIGHT:  image_height     <= cfg_wdata[12:0];
        pprg_pkg::REG_SAMPLES:       samples_per_side <= cfg_wdata[4:0];
      endcase
    end
  end

  // clamped sample grid and image sides
  logic [4:0]  n_eff;
  logic [12:0] wd_eff, ht_eff;

  always_comb begin
    priority if (samples_per_side == '0) n_eff = 5'd1;
    else if (samples_per_side > 5'(pprg_pkg::MAX_SAMPLES_PER_SIDE))
      n_eff = 5'(pprg_pkg::MAX_SAMPLES_PER_SIDE);
    else n_eff = samples_per_side;
    wd_eff = (image_width > 13'(pprg_pkg::MAX_IMAGE_SIDE)) ?
             13'(pprg_pkg::MAX_IMAGE_SIDE) : image_width;
    ht_eff = (image_height > 13'(pprg_pkg::MAX_IMAGE_SIDE)) ?
             13'(pprg_pkg::MAX_IMAGE_SIDE) : image_height;
  end

  // stage enables: a stage loads when empty or when the next one moves
  logic [NS-1:0] vld;
  logic [NS:0]   en;
  logic [NS-1:0] vld_in;

  always_comb begin
    en[NS] = ray.ready;
    for (int i = NS - 1; i >= 0; i--) en[i] = !vld[i] || en[i+1];
  end

  assign vld_in    = {vld[NS-2:0], req.valid};
  assign req.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) if (en[i]) vld[i] <= vld_in[i];
    end
  end

  // stage 0: offsets in 1/(2n) pixel units, d*n
  logic [16:0]        ncol, nrow;
  logic [17:0]        nwd, nht;
  logic signed [18:0] s0_tx, s0_ty;
  logic [28:0]        s0_dn;

  assign ncol = 17'(n_eff) * 17'(req.pixel_col);
  assign nrow = 17'(n_eff) * 17'(req.pixel_row);
  assign nwd  = 18'(n_eff) * 18'(wd_eff);
  assign nht  = 18'(n_eff) * 18'(ht_eff);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_tx <= $signed({1'b0, ncol, 1'b0}) - $signed({1'b0, nwd})
             + $signed({14'd0, req.sub_col, 1'b1});
      s0_ty <= $signed({1'b0, nrow, 1'b0}) - $signed({1'b0, nht})
             + $signed({14'd0, req.sub_row, 1'b1});
      s0_dn <= 29'(view_distance) * 29'(n_eff);
    end
  end

  // stage 1: scale by pixel size
  logic signed [43:0] s1_a, s1_b;
  logic [28:0]        s1_dn;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_a  <= $signed({1'b0, pixel_size}) * s0_tx;
      s1_b  <= $signed({1'b0, pixel_size}) * s0_ty;
      s1_dn <= s0_dn;
    end
  end

  // stage 2: products with the camera axes
  logic signed [59:0] s2_pu [3];
  logic signed [59:0] s2_pv [3];
  logic signed [45:0] s2_pw [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        s2_pu[k] <= s1_a * $signed(basis_u[16*k +: 16]);
        s2_pv[k] <= s1_b * $signed(basis_v[16*k +: 16]);
        s2_pw[k] <= $signed({1'b0, s1_dn}) * $signed(basis_w[16*k +: 16]);
      end
    end
  end

  // stage 3: x*u + y*v - d*w (w term carries the 2^9 of d's Q16.8 and the 2)
  logic signed [59:0] s3_c [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++)
        s3_c[k] <= s2_pu[k] + s2_pv[k] - (60'(s2_pw[k]) <<< 9);
    end
  end

  // stage 4: sign and magnitude
  logic [2:0][59:0] s4_mag;
  logic [2:0]       s4_neg;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        s4_neg[k] <= s3_c[k][59];
        s4_mag[k] <= s3_c[k][59] ? 60'(-s3_c[k]) : 60'(s3_c[k]);
      end
    end
  end

  // stage 5: largest magnitude
  logic [2:0][59:0] s5_mag;
  logic [2:0]       s5_neg;
  logic [59:0]      s5_m;
  logic             s5_zero;
  logic [59:0]      m01, m012;

  assign m01  = (s4_mag[1] > s4_mag[0]) ? s4_mag[1] : s4_mag[0];
  assign m012 = (s4_mag[2] > m01) ? s4_mag[2] : m01;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_mag  <= s4_mag;
      s5_neg  <= s4_neg;
      s5_m    <= m012;
      s5_zero <= (m012 == '0);
    end
  end

  // normalise: shift left until the largest magnitude has its top bit at 59
  logic [2:0][59:0] nm_mag  [NRM_N];
  logic [59:0]      nm_m    [NRM_N];
  logic [2:0]       nm_neg  [NRM_N];
  logic             nm_zero [NRM_N];

  for (genvar j = 0; j < NRM_N; j++) begin : g_nrm
    localparam int SH = 32 >> j;
    logic [2:0][59:0] src_mag;
    logic [59:0]      src_m;
    logic [2:0]       src_neg;
    logic             src_zero;

    if (j == 0) begin : g_first
      assign src_mag  = s5_mag;
      assign src_m    = s5_m;
      assign src_neg  = s5_neg;
      assign src_zero = s5_zero;
    end else begin : g_next
      assign src_mag  = nm_mag[j-1];
      assign src_m    = nm_m[j-1];
      assign src_neg  = nm_neg[j-1];
      assign src_zero = nm_zero[j-1];
    end

    always_ff @(posedge clk) begin
      if (en[ST_NRM0+j]) begin
        nm_neg[j]  <= src_neg;
        nm_zero[j] <= src_zero;
        if (src_m[59 -: SH] == '0) begin
          nm_m[j] <= src_m << SH;
          for (int k = 0; k < 3; k++) nm_mag[j][k] <= src_mag[k] << SH;
        end else begin
          nm_m[j]   <= src_m;
          nm_mag[j] <= src_mag;
        end
      end
    end
  end

  // squares of the 30-bit normalised magnitudes
  logic [2:0][29:0] sq_mn;
  logic [59:0]      sq_sq [3];
  logic [2:0]       sq_neg;
  logic             sq_zero;

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int k = 0; k < 3; k++) begin
        sq_mn[k] <= nm_mag[NRM_N-1][k][59:30];
        sq_sq[k] <= 60'(nm_mag[NRM_N-1][k][59:30]) * 60'(nm_mag[NRM_N-1][k][59:30]);
      end
      sq_neg  <= nm_neg[NRM_N-1];
      sq_zero <= nm_zero[NRM_N-1];
    end
  end

  // sum of squares
  logic [61:0]      ss_sum;
  logic [2:0][29:0] ss_mn;
  logic [2:0]       ss_neg;
  logic             ss_zero;

  always_ff @(posedge clk) begin
    if (en[ST_SSUM]) begin
      ss_sum  <= 62'(sq_sq[0]) + 62'(sq_sq[1]) + 62'(sq_sq[2]);
      ss_mn   <= sq_mn;
      ss_neg  <= sq_neg;
      ss_zero <= sq_zero;
    end
  end

  // integer square root, one result bit per stage
  logic [63:0]      rt_rem  [RT_N];
  logic [63:0]      rt_res  [RT_N];
  logic [2:0][29:0] rt_mn   [RT_N];
  logic [2:0]       rt_neg  [RT_N];
  logic             rt_zero [RT_N];

  for (genvar j = 0; j < RT_N; j++) begin : g_rt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0]      src_rem, src_res, trial;
    logic [2:0][29:0] src_mn;
    logic [2:0]       src_neg;
    logic             src_zero;

    if (j == 0) begin : g_first
      assign src_rem  = {2'b00, ss_sum};
      assign src_res  = '0;
      assign src_mn   = ss_mn;
      assign src_neg  = ss_neg;
      assign src_zero = ss_zero;
    end else begin : g_next
      assign src_rem  = rt_rem[j-1];
      assign src_res  = rt_res[j-1];
      assign src_mn   = rt_mn[j-1];
      assign src_neg  = rt_neg[j-1];
      assign src_zero = rt_zero[j-1];
    end

    assign trial = src_res + BIT;

    always_ff @(posedge clk) begin
      if (en[ST_RT0+j]) begin
        rt_mn[j]   <= src_mn;
        rt_neg[j]  <= src_neg;
        rt_zero[j] <= src_zero;
        if (src_rem >= trial) begin
          rt_rem[j] <= src_rem - trial;
          rt_res[j] <= (src_res >> 1) + BIT;
        end else begin
          rt_rem[j] <= src_rem;
          rt_res[j] <= src_res >> 1;
        end
      end
    end
  end

  // dividends with rounding term
  logic [RW-1:0] dp_num [3];
  logic [30:0]   dp_len;
  logic [2:0]    dp_neg;
  logic          dp_zero;
  logic [30:0]   rt_len;

  assign rt_len = rt_res[RT_N-1][30:0];

  always_ff @(posedge clk) begin
    if (en[ST_DIVP]) begin
      for (int k = 0; k < 3; k++)
        dp_num[k] <= (RW'(rt_mn[RT_N-1][k]) << DIR_FRAC_BITS) + RW'(rt_len >> 1);
      dp_len  <= rt_len;
      dp_neg  <= rt_neg[RT_N-1];
      dp_zero <= rt_zero[RT_N-1];
    end
  end

  // restoring divide, one quotient bit per stage for each lane
  logic [2:0][RW-1:0] dv_rem  [QW];
  logic [2:0][QW-1:0] dv_q    [QW];
  logic [30:0]        dv_len  [QW];
  logic [2:0]         dv_neg  [QW];
  logic               dv_zero [QW];

  for (genvar j = 0; j < QW; j++) begin : g_dv
    localparam int QI = QW - 1 - j;
    localparam logic [QW-1:0] QBIT = QW'(1) << QI;
    logic [2:0][RW-1:0] src_rem;
    logic [2:0][QW-1:0] src_q;
    logic [30:0]        src_len;
    logic [2:0]         src_neg;
    logic               src_zero;
    logic [RW-1:0]      dvs;

    if (j == 0) begin : g_first
      assign src_rem  = {dp_num[2], dp_num[1], dp_num[0]};
      assign src_q    = '0;
      assign src_len  = dp_len;
      assign src_neg  = dp_neg;
      assign src_zero = dp_zero;
    end else begin : g_next
      assign src_rem  = dv_rem[j-1];
      assign src_q    = dv_q[j-1];
      assign src_len  = dv_len[j-1];
      assign src_neg  = dv_neg[j-1];
      assign src_zero = dv_zero[j-1];
    end

    assign dvs = RW'(src_len) << QI;

    always_ff @(posedge clk) begin
      if (en[ST_DV0+j]) begin
        dv_len[j]  <= src_len;
        dv_neg[j]  <= src_neg;
        dv_zero[j] <= src_zero;
        for (int k = 0; k < 3; k++) begin
          if (src_rem[k] >= dvs) begin
            dv_rem[j][k] <= src_rem[k] - dvs;
            dv_q[j][k]   <= src_q[k] | QBIT;
          end else begin
            dv_rem[j][k] <= src_rem[k];
            dv_q[j][k]   <= src_q[k];
          end
        end
      end
    end
  end

  // saturate to signed 16 bits and apply sign
  function automatic logic [15:0] sat_dir(input logic [QW-1:0] q, input logic ng);
    logic [31:0] r;
    r = 32'(q);
    if (ng) return (r > 32'd32768) ? 16'h8000 : 16'(-r);
    else    return (r > 32'd32767) ? 16'h7fff : 16'(r);
  endfunction

  logic [2:0][15:0] ot_dir;
  logic             ot_zero;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      ot_zero <= dv_zero[QW-1];
      for (int k = 0; k < 3; k++)
        ot_dir[k] <= dv_zero[QW-1] ? 16'h0000 :
                     sat_dir(dv_q[QW-1][k], dv_neg[QW-1][k]);
    end
  end

  assign ray.valid       = vld[NS-1];
  assign ray.dir_x       = $signed(ot_dir[0]);
  assign ray.dir_y       = $signed(ot_dir[1]);
  assign ray.dir_z       = $signed(ot_dir[2]);
  assign ray.zero_length = ot_zero;

endmodule
`default_nettype wire

// ===== hdl/pprg_checker.sv =====
// Checker on the ray generator's output port, with its bind.
`default_nettype none
module pprg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               ray_valid,
  input wire logic               ray_ready,
  input wire logic signed [15:0] dir_x,
  input wire logic signed [15:0] dir_y,
  input wire logic signed [15:0] dir_z,
  input wire logic               zero_length
);

  // a held ray keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ray_valid && !ray_ready |=> ray_valid && $stable({dir_x, dir_y, dir_z, zero_length}))
    else $error("ray changed while stalled");

  // zero vector gives zero direction
  a_zero_dir: assert property (@(posedge clk) disable iff (rst)
    ray_valid && zero_length |-> dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0)
    else $error("zero_length ray with non-zero direction");

  // a unit direction never vanishes
  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    ray_valid && !zero_length |-> dir_x != 16'sd0 || dir_y != 16'sd0 || dir_z != 16'sd0)
    else $error("normalised direction is zero");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !ray_valid)
    else $error("ray valid right after reset");

endmodule

bind pinhole_primary_ray_generator_unit pprg_checker u_pprg_checker (
  .clk        (clk),
  .rst        (rst),
  .ray_valid  (ray.valid),
  .ray_ready  (ray.ready),
  .dir_x      (ray.dir_x),
  .dir_y      (ray.dir_y),
  .dir_z      (ray.dir_z),
  .zero_length(ray.zero_length)
);
`default_nettype wire
